@@ src/ght_pkg.sv @@
`timescale 1ns / 1ps
// ght_pkg: shared types and codes for the generation handle table
// depends on nothing; used by ght_ctrl, ght_datapath and the top level
package ght_pkg;

   // fixed widths of the transaction fields
   localparam int unsigned OP_W        = 2;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned HANDLE_W    = 32;
   localparam int unsigned NEW_INDEX_W = 6;
   localparam int unsigned PORT_VAL_W  = 32;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE  = 2'd0,
      OP_FIND    = 2'd1,
      OP_REBIND  = 2'd2,
      OP_RELEASE = 2'd3
   } ght_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_REJECT = 2'd1,
      STATUS_FULL   = 2'd2
   } ght_status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } ght_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch request, launch slot memory reads
      logic execute;   // apply update, load response register
   } ght_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;  // response register empty or draining this cycle
   } ght_stat_type;

endpackage

@@ src/generation_handle_table.sv @@
`timescale 1ns / 1ps
// generation_handle_table: top level, handle table with generation checked slots
// depends on ght_pkg, ght_ctrl, ght_datapath (and ght_ram through the datapath)
//
// usage
//   request channel (req_*): one transaction per operation: create, find, rebind
//   or release. create takes the lowest free slot; the others carry a handle
//   (handle_ok, slot_index, slot_generation) that is checked before use.
//   response channel (rsp_*): exactly one transaction per request, in order,
//   with status ok, rejected or table full.
// order: slot memories have a registered read, so a request is captured and its slot read,
//   then in exec, once the response register is free, the slot is updated and rsp_* loaded.
//   a new request is taken only after the previous one has executed.
// reset: every slot free with generation zero; stored values are undefined
//   until written. no clearing pass is needed, a fill count stands in for the
//   generation memory's reset. requests are taken as soon as reset is released.
// receiver stall: the response register holds its transaction. one more request
//   is accepted and read meanwhile, then it waits until the register frees.
module generation_handle_table #(
   parameter int unsigned TABLE_DEPTH = 64,
   parameter int unsigned GEN_WIDTH   = 32,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ght_pkg::OP_W-1:0]          req_operation,
   input  logic                              req_handle_ok,
   input  logic [ght_pkg::HANDLE_W-1:0]      req_slot_index,
   input  logic [ght_pkg::HANDLE_W-1:0]      req_slot_generation,
   input  logic [ght_pkg::PORT_VAL_W-1:0]    req_value_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ght_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ght_pkg::NEW_INDEX_W-1:0]   rsp_new_index,
   output logic [ght_pkg::HANDLE_W-1:0]      rsp_new_generation,
   output logic [ght_pkg::PORT_VAL_W-1:0]    rsp_value_out
);
   import ght_pkg::*;

   // command and status between the sequencer and the datapath
   ght_cmd_type  dp_cmd;
   ght_stat_type dp_stat;

   // sequencer: idle takes a request, exec waits for a free response register
   ght_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   // datapath: slot state, memories, handle checks and the response register
   ght_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .GEN_WIDTH   (GEN_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .dp_cmd              (dp_cmd),
      .dp_stat             (dp_stat),
      .req_operation       (req_operation),
      .req_handle_ok       (req_handle_ok),
      .req_slot_index      (req_slot_index),
      .req_slot_generation (req_slot_generation),
      .req_value_in        (req_value_in),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_new_index       (rsp_new_index),
      .rsp_new_generation  (rsp_new_generation),
      .rsp_value_out       (rsp_value_out)
   );

endmodule

@@ src/ght_ram.sv @@
`timescale 1ns / 1ps
// ght_ram: generic single write port, single read port ram with registered read
// depends on nothing
module ght_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ght_ctrl.sv @@
`timescale 1ns / 1ps
// ght_ctrl: request sequencer, capture then execute
// depends on ght_pkg
module ght_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ght_pkg::ght_stat_type dp_stat,
   output ght_pkg::ght_cmd_type  dp_cmd
);
   import ght_pkg::*;

   ght_state_type state_ff;
   ght_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (dp_stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      dp_cmd.capture = 1'b0;
      dp_cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            dp_cmd.capture = req_valid;
         end
         ST_EXEC: begin
            dp_cmd.execute = dp_stat.out_free;
         end
         default: ;
      endcase
   end

endmodule

@@ src/ght_datapath.sv @@
`timescale 1ns / 1ps
// ght_datapath: free marks, fill count, slot memories, handle checks, response register
// depends on ght_pkg and ght_ram
module ght_datapath #(
   parameter int unsigned TABLE_DEPTH = 64,
   parameter int unsigned GEN_WIDTH   = 32,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ght_pkg::ght_cmd_type              dp_cmd,
   output ght_pkg::ght_stat_type             dp_stat,
   input  logic [ght_pkg::OP_W-1:0]          req_operation,
   input  logic                              req_handle_ok,
   input  logic [ght_pkg::HANDLE_W-1:0]      req_slot_index,
   input  logic [ght_pkg::HANDLE_W-1:0]      req_slot_generation,
   input  logic [ght_pkg::PORT_VAL_W-1:0]    req_value_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ght_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ght_pkg::NEW_INDEX_W-1:0]   rsp_new_index,
   output logic [ght_pkg::HANDLE_W-1:0]      rsp_new_generation,
   output logic [ght_pkg::PORT_VAL_W-1:0]    rsp_value_out
);
   import ght_pkg::*;

   localparam int unsigned IW = $clog2(TABLE_DEPTH);

   // slot state held in flops
   logic [TABLE_DEPTH-1:0] free_ff, free_in;
   logic [IW:0]            fill_ff, fill_in;

   // captured request
   logic [OP_W-1:0]        op_ff;
   logic                   ok_ff;
   logic                   idx_ok_ff;
   logic                   full_ff;
   logic [IW-1:0]          slot_ff;
   logic [HANDLE_W-1:0]    gen_req_ff;
   logic [VALUE_WIDTH-1:0] value_ff;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [NEW_INDEX_W-1:0] new_index_ff, new_index_in;
   logic [HANDLE_W-1:0]    new_gen_ff, new_gen_in;
   logic [PORT_VAL_W-1:0]  value_out_ff, value_out_in;

   logic [IW-1:0]          lowest_free;
   logic                   any_free;
   logic [IW-1:0]          rd_slot;
   logic [GEN_WIDTH-1:0]   gen_rd, gen_cur, gen_next;
   logic [VALUE_WIDTH-1:0] val_rd;
   logic                   gen_wr, val_wr;
   logic                   handle_match;
   logic                   slot_used;

   // lowest free slot
   always_comb begin
      lowest_free = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (free_ff[i]) lowest_free = IW'(i);
      end
      any_free = |free_ff;
   end

   assign rd_slot = (req_operation == OP_CREATE) ? lowest_free : req_slot_index[IW-1:0];

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         op_ff      <= req_operation;
         ok_ff      <= req_handle_ok;
         idx_ok_ff  <= (req_slot_index < HANDLE_W'(TABLE_DEPTH));
         full_ff    <= !any_free;
         slot_ff    <= rd_slot;
         gen_req_ff <= req_slot_generation;
         value_ff   <= VALUE_WIDTH'(req_value_in);
      end
   end

   ght_ram #(.WIDTH(GEN_WIDTH), .DEPTH(TABLE_DEPTH)) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_wr),
      .wr_addr (slot_ff),
      .wr_data (gen_next),
      .rd_en   (dp_cmd.capture),
      .rd_addr (rd_slot),
      .rd_data (gen_rd)
   );

   ght_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr),
      .wr_addr (slot_ff),
      .wr_data (value_ff),
      .rd_en   (dp_cmd.capture),
      .rd_addr (rd_slot),
      .rd_data (val_rd)
   );

   // slots at or above the fill count were never created and still hold generation zero
   assign gen_cur      = ({1'b0, slot_ff} < fill_ff) ? gen_rd : '0;
   assign gen_next     = gen_cur + GEN_WIDTH'(1);
   assign handle_match = ok_ff && idx_ok_ff && (HANDLE_W'(gen_cur) == gen_req_ff);
   assign slot_used    = !free_ff[slot_ff];

   always_comb begin
      free_in      = free_ff;
      fill_in      = fill_ff;
      gen_wr       = 1'b0;
      val_wr       = 1'b0;
      status_in    = STATUS_REJECT;
      new_index_in = '0;
      new_gen_in   = '0;
      value_out_in = '0;
      case (op_ff)
         OP_CREATE: begin
            if (full_ff) begin
               status_in = STATUS_FULL;
            end else begin
               status_in        = STATUS_OK;
               new_index_in     = NEW_INDEX_W'(slot_ff);
               new_gen_in       = HANDLE_W'(gen_next);
               gen_wr           = dp_cmd.execute;
               val_wr           = dp_cmd.execute;
               free_in[slot_ff] = 1'b0;
               if ({1'b0, slot_ff} == fill_ff) fill_in = fill_ff + (IW+1)'(1);
            end
         end
         OP_FIND: begin
            if (handle_match && slot_used) begin
               status_in    = STATUS_OK;
               value_out_in = PORT_VAL_W'(val_rd);
            end
         end
         OP_REBIND: begin
            if (handle_match && slot_used) begin
               status_in = STATUS_OK;
               val_wr    = dp_cmd.execute;
            end
         end
         default: begin
            // release frees the slot even when it was already free
            if (handle_match) begin
               status_in        = STATUS_OK;
               value_out_in     = PORT_VAL_W'(val_rd);
               free_in[slot_ff] = 1'b1;
            end
         end
      endcase
   end

   assign dp_stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (dp_cmd.execute) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff      <= '1;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (dp_cmd.execute) begin
            free_ff <= free_in;
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.execute) begin
         status_ff    <= status_in;
         new_index_ff <= new_index_in;
         new_gen_ff   <= new_gen_in;
         value_out_ff <= value_out_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_new_index      = new_index_ff;
   assign rsp_new_generation = new_gen_ff;
   assign rsp_value_out      = value_out_ff;

endmodule

@@ bench/ght_answer_check.sv @@
`timescale 1ns / 1ps
// ght_answer_check: watches the request and response channels of the handle table,
// predicts every response from its own copy of the slots and compares field by field
// depends on ght_pkg; instantiated by tb beside generation_handle_table
module ght_answer_check #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [ght_pkg::OP_W-1:0]            req_operation,
   input  logic                                req_handle_ok,
   input  logic [ght_pkg::HANDLE_W-1:0]        req_slot_index,
   input  logic [ght_pkg::HANDLE_W-1:0]        req_slot_generation,
   input  logic [ght_pkg::PORT_VAL_W-1:0]      req_value_in,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [ght_pkg::STATUS_W-1:0]        rsp_status,
   input  logic [ght_pkg::NEW_INDEX_W-1:0]     rsp_new_index,
   input  logic [ght_pkg::HANDLE_W-1:0]        rsp_new_generation,
   input  logic [ght_pkg::PORT_VAL_W-1:0]      rsp_value_out,
   output int                                  mismatch_count,
   output int                                  answers_pending
);
   import ght_pkg::*;

   typedef struct {
      ght_status_type               status;
      logic [NEW_INDEX_W-1:0]       index;
      logic [HANDLE_W-1:0]          generation;
      logic [PORT_VAL_W-1:0]        value;
   } table_answer_type;

   table_answer_type        answers_due[$];
   table_answer_type        oldest_answer;
   logic                    slot_free  [TABLE_DEPTH];
   logic [HANDLE_W-1:0]     slot_gen   [TABLE_DEPTH];
   logic [PORT_VAL_W-1:0]   slot_value [TABLE_DEPTH];

   initial begin
      mismatch_count  = 0;
      answers_pending = 0;
   end

   task automatic report(string what, logic [31:0] want, logic [31:0] got);
      if (mismatch_count < 100)
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // applies one request to the slot copy and returns the answer it must produce
   function automatic table_answer_type predict_table_answer(ght_op_type op, logic ok,
         logic [HANDLE_W-1:0] index, logic [HANDLE_W-1:0] generation,
         logic [PORT_VAL_W-1:0] value);
      table_answer_type answer;
      int unsigned      slot;
      answer.status     = STATUS_REJECT;
      answer.index      = '0;
      answer.generation = '0;
      answer.value      = '0;
      if (op == OP_CREATE) begin
         answer.status = STATUS_FULL;
         for (int s = 0; s < TABLE_DEPTH; s++) begin
            if (slot_free[s]) begin
               slot_gen[s]       = slot_gen[s] + 1'b1;
               slot_value[s]     = value;
               slot_free[s]      = 1'b0;
               answer.status     = STATUS_OK;
               answer.index      = NEW_INDEX_W'(s);
               answer.generation = slot_gen[s];
               break;
            end
         end
      end else if (ok && index < TABLE_DEPTH) begin
         slot = index;
         if (slot_gen[slot] == generation) begin
            case (op)
               OP_FIND: begin
                  if (!slot_free[slot]) begin
                     answer.status = STATUS_OK;
                     answer.value  = slot_value[slot];
                  end
               end
               OP_REBIND: begin
                  if (!slot_free[slot]) begin
                     answer.status    = STATUS_OK;
                     slot_value[slot] = value;
                  end
               end
               default: begin
                  answer.status   = STATUS_OK;
                  answer.value    = slot_value[slot];
                  slot_free[slot] = 1'b1;
               end
            endcase
         end
      end
      return answer;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < TABLE_DEPTH; s++) begin
            slot_free[s]  = 1'b1;
            slot_gen[s]   = '0;
            slot_value[s] = '0;
         end
         answers_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               report("response with no request pending", 0, 0);
            end else begin
               oldest_answer = answers_due.pop_front();
               if (rsp_status !== oldest_answer.status)
                  report("status", oldest_answer.status, rsp_status);
               if (rsp_new_index !== oldest_answer.index)
                  report("new_index", oldest_answer.index, rsp_new_index);
               if (rsp_new_generation !== oldest_answer.generation)
                  report("new_generation", oldest_answer.generation, rsp_new_generation);
               if (rsp_value_out !== oldest_answer.value)
                  report("value_out", oldest_answer.value, rsp_value_out);
            end
         end
         if (req_valid && req_ready)
            answers_due.push_back(predict_table_answer(ght_op_type'(req_operation),
               req_handle_ok, req_slot_index, req_slot_generation, req_value_in));
      end
      answers_pending = answers_due.size();
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// tb: stimulus and verdict for generation_handle_table
// depends on ght_pkg, generation_handle_table and ght_answer_check
module tb;
   import ght_pkg::*;

   localparam int unsigned DEPTH          = 64;
   localparam int unsigned PHASE_ITEMS    = 500;
   localparam int unsigned TIDE_ITEMS     = 128;
   localparam int unsigned DRAIN_CYCLES   = 2000;

   logic                      clock               = 1'b0;
   logic                      reset               = 1'b1;
   logic                      req_valid           = 1'b0;
   logic                      req_ready;
   logic [OP_W-1:0]           req_operation       = '0;
   logic                      req_handle_ok       = 1'b0;
   logic [HANDLE_W-1:0]       req_slot_index      = '0;
   logic [HANDLE_W-1:0]       req_slot_generation = '0;
   logic [PORT_VAL_W-1:0]     req_value_in        = '0;
   logic                      rsp_valid;
   logic                      rsp_ready           = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic [NEW_INDEX_W-1:0]    rsp_new_index;
   logic [HANDLE_W-1:0]       rsp_new_generation;
   logic [PORT_VAL_W-1:0]     rsp_value_out;

   int mismatch_count;
   int answers_pending;

   // idle rates in percent, changed per phase
   int idle_pct  = 0;
   int stall_pct = 0;

   // slot picture kept only to aim handles at live, stale or free slots
   logic [HANDLE_W-1:0] shadow_gen  [DEPTH];
   bit                  shadow_used [DEPTH];

   always #2 clock = ~clock;

   generation_handle_table #(
      .TABLE_DEPTH (DEPTH),
      .GEN_WIDTH   (32),
      .VALUE_WIDTH (32)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_handle_ok       (req_handle_ok),
      .req_slot_index      (req_slot_index),
      .req_slot_generation (req_slot_generation),
      .req_value_in        (req_value_in),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_new_index       (rsp_new_index),
      .rsp_new_generation  (rsp_new_generation),
      .rsp_value_out       (rsp_value_out)
   );

   ght_answer_check #(
      .TABLE_DEPTH (DEPTH)
   ) i_answer_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_handle_ok       (req_handle_ok),
      .req_slot_index      (req_slot_index),
      .req_slot_generation (req_slot_generation),
      .req_value_in        (req_value_in),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_new_index       (rsp_new_index),
      .rsp_new_generation  (rsp_new_generation),
      .rsp_value_out       (rsp_value_out),
      .mismatch_count      (mismatch_count),
      .answers_pending     (answers_pending)
   );

   // receiver side: ready redrawn every cycle at the current stall rate
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // keep the handle picture in step with each accepted transaction
   function automatic void track_slots(ght_op_type op, logic ok, logic [HANDLE_W-1:0] index,
         logic [HANDLE_W-1:0] generation);
      if (op == OP_CREATE) begin
         for (int s = 0; s < DEPTH; s++) begin
            if (!shadow_used[s]) begin
               shadow_used[s] = 1'b1;
               shadow_gen[s]  = shadow_gen[s] + 1'b1;
               break;
            end
         end
      end else if (op == OP_RELEASE && ok && index < DEPTH) begin
         if (shadow_gen[index] == generation)
            shadow_used[index] = 1'b0;
      end
   endfunction

   // drive one request transaction, with random idle cycles ahead of it
   task automatic send_request(ght_op_type op, logic ok, logic [HANDLE_W-1:0] index,
         logic [HANDLE_W-1:0] generation, logic [PORT_VAL_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_handle_ok       <= ok;
      req_slot_index      <= index;
      req_slot_generation <= generation;
      req_value_in        <= value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      track_slots(op, ok, index, generation);
      @(negedge clock);
   endtask

   function automatic logic [PORT_VAL_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // one random request; create and release weights set whether the table fills or drains
   task automatic random_request(int create_pct, int release_pct);
      ght_op_type          op;
      logic                ok;
      logic [HANDLE_W-1:0] index;
      logic [HANDLE_W-1:0] generation;
      int                  live[$];
      int                  slot;
      int                  pick;
      for (int s = 0; s < DEPTH; s++)
         if (shadow_used[s])
            live.push_back(s);
      // default: well-formed handle to a live slot, or any slot when none is live
      slot       = live.size() > 0 ? live[$urandom_range(live.size() - 1)]
                                   : $urandom_range(DEPTH - 1);
      ok         = 1'b1;
      index      = slot;
      generation = shadow_gen[slot];
      pick       = $urandom_range(99);
      if (pick < create_pct) begin
         op = OP_CREATE;
         // handle fields are don't-care on create, so fill them with noise
         ok         = $urandom_range(1);
         index      = $urandom;
         generation = $urandom;
      end else begin
         if (pick < create_pct + release_pct)
            op = OP_RELEASE;
         else
            op = $urandom_range(1) ? OP_FIND : OP_REBIND;
         pick = $urandom_range(99);
         if (pick < 70) begin
            // keep the well-formed handle
         end else if (pick < 78) begin
            // current generation of any slot, often a freed one
            slot       = $urandom_range(DEPTH - 1);
            index      = slot;
            generation = shadow_gen[slot];
         end else if (pick < 84) begin
            ok = 1'b0;
         end else if (pick < 90) begin
            index = $urandom;
            if (index < DEPTH)
               index = $urandom_range(1) ? DEPTH : '1;
         end else if (pick < 96) begin
            // stale or future generation
            generation = $urandom_range(1) ? generation + 1'b1 : generation - 1'b1;
         end else begin
            ok         = $urandom_range(1);
            index      = $urandom_range(DEPTH - 1);
            generation = $urandom;
         end
      end
      // a matching release on a never created slot would read an unwritten value
      if (op == OP_RELEASE && ok && index < DEPTH && shadow_gen[index] == 0
            && generation == 0)
         generation = 1;
      send_request(op, ok, index, generation, pick_value());
   endtask

   initial begin
      int waited;
      for (int s = 0; s < DEPTH; s++) begin
         shadow_gen[s]  = '0;
         shadow_used[s] = 1'b0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, every generation at zero
      send_request(OP_CREATE,  1'b0, '0, '0, '0);               // slot 0, generation 1
      send_request(OP_CREATE,  1'b0, '0, '0, '1);               // slot 1, generation 1
      send_request(OP_FIND,    1'b1, 0, 1, '0);
      send_request(OP_FIND,    1'b1, 1, 1, '0);
      send_request(OP_REBIND,  1'b1, 0, 1, 32'hA5A5_A5A5);
      send_request(OP_FIND,    1'b1, 0, 1, '0);
      send_request(OP_RELEASE, 1'b1, 1, 1, '0);
      // release of a slot already free still answers ok with its value
      send_request(OP_RELEASE, 1'b1, 1, 1, '0);
      // find and rebind on a free slot are rejected
      send_request(OP_FIND,    1'b1, 1, 1, '0);
      send_request(OP_REBIND,  1'b1, 1, 1, 32'h1234_5678);
      // malformed handle, index out of range just past the table and at the maximum, generation mismatch
      send_request(OP_FIND,    1'b0, 0, 1, '0);
      send_request(OP_FIND,    1'b1, DEPTH, 1, '0);
      send_request(OP_RELEASE, 1'b1, '1, 1, '0);
      send_request(OP_FIND,    1'b1, 0, '1, '0);
      send_request(OP_REBIND,  1'b1, 0, 0, '1);
      // never created slot with a nonzero generation
      send_request(OP_RELEASE, 1'b1, 5, 1, '0);
      // reuse of the freed slot bumps its generation, old handle goes stale
      send_request(OP_CREATE,  1'b1, '1, '1, 32'h1234_5678);
      send_request(OP_FIND,    1'b1, 1, 1, '0);
      send_request(OP_FIND,    1'b1, 1, 2, '0);
      send_request(OP_RELEASE, 1'b1, 0, 1, '0);
      send_request(OP_CREATE,  1'b0, '0, '0, 32'h8000_0001);
      send_request(OP_RELEASE, 1'b1, 0, 2, '0);

      // random: four phases of idle and stall rates, each swinging between filling and draining
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 51; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 51; end
            default: begin idle_pct = 18; stall_pct = 18; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ((n / TIDE_ITEMS) % 2 == 0)
               random_request(60, 10);   // mostly creates, so the table fills up
            else
               random_request(10, 50);   // drain back down
         end
      end
      req_valid <= 1'b0;
      idle_pct  = 0;
      stall_pct = 0;

      // drain: wait for every response back, then check for anything stray before the verdict
      waited = 0;
      while (answers_pending != 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      if (answers_pending != 0) begin
         $display("Verification failed");
      end else begin
         repeat (8) @(posedge clock);
         if (mismatch_count == 0 && answers_pending == 0)
            $display("Verification passed");
         else
            $display("Verification failed");
      end
      $finish;
   end

endmodule
